// ===== rtl/core/bcdc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the button click duration classifier.
// No dependencies; used by button_click_duration_classifier_top.
package bcdc_pkg;

  // Sizing
  localparam int NUM_BUTTONS = 8;
  localparam int TIMER_BITS  = 16;
  localparam int ADDR_W      = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int INDEX_W     = 3;
  localparam int COUNT_W     = 4;
  localparam int THRESH_W    = 16;
  localparam int CMP_W       = (TIMER_BITS > THRESH_W) ? TIMER_BITS : THRESH_W;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_BUTTONS_IN_USE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_THRESHOLD  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MEDIUM_THRESHOLD = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_THRESHOLD   = 2'd3;

  // Configuration reset values
  localparam logic [COUNT_W-1:0]  RESET_BUTTONS_IN_USE   = 4'd0;
  localparam logic [THRESH_W-1:0] RESET_SHORT_THRESHOLD  = 16'd5;
  localparam logic [THRESH_W-1:0] RESET_MEDIUM_THRESHOLD = 16'd50;
  localparam logic [THRESH_W-1:0] RESET_LONG_THRESHOLD   = 16'd200;

  // Click classes
  typedef enum logic [1:0] {
    CLASS_NONE   = 2'd0,
    CLASS_SHORT  = 2'd1,
    CLASS_MEDIUM = 2'd2,
    CLASS_LONG   = 2'd3
  } class_t;

  // Per-button state entry as stored in memory
  typedef struct packed {
    logic                  previous_level;
    logic                  timing_active;
    logic                  released_seen;
    logic [TIMER_BITS-1:0] press_timer;
    class_t                recorded_class;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/core/button_click_duration_classifier_top.sv =====
`timescale 1ns / 1ps
// Button click duration classifier: per-button state memory with read-modify-write.
// Depends on bcdc_pkg for sizing, class codes and the entry layout.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+-------------------------------------------
//  sample    | sample_valid, sample_stall | button_index, pin_level
//  result    | result_valid, result_stall | result_index, click_event, held_class,
//            |                            | ignored
//  config    | cfg_write                  | cfg_index, cfg_data
//
// One item per cycle sustained while the result side does not stall; an item is taken
// into the working stage, and its result is registered in the output register when that
// stage advances. The state memory is read on the taking edge and written back from the
// working stage as it advances; a back-to-back item for the same button takes the written
// entry from a bypass register. Synchronous reset clears per-entry valid bits, so all
// buttons read as zero at once. A stalled result holds the working stage; once that
// stage is full the sample side stalls in the same cycle.
module button_click_duration_classifier_top (
  input  logic                               clk,
  input  logic                               rst,
  // sample channel
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  logic [bcdc_pkg::INDEX_W-1:0]       button_index,
  input  logic                               pin_level,
  // result channel
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [bcdc_pkg::INDEX_W-1:0]       result_index,
  output logic [1:0]                         click_event,
  output logic [1:0]                         held_class,
  output logic                               ignored,
  // configuration port
  input  logic                               cfg_write,
  input  logic [bcdc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bcdc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Configuration registers
  logic [bcdc_pkg::COUNT_W-1:0]  buttons_in_use;
  logic [bcdc_pkg::THRESH_W-1:0] short_threshold;
  logic [bcdc_pkg::THRESH_W-1:0] medium_threshold;
  logic [bcdc_pkg::THRESH_W-1:0] long_threshold;

  // State memory and valid bits
  bcdc_pkg::entry_t               state_mem [bcdc_pkg::NUM_BUTTONS];
  logic [bcdc_pkg::NUM_BUTTONS-1:0] entry_valid;

  // Working stage
  logic                           work_valid;
  logic [bcdc_pkg::INDEX_W-1:0]   work_index;
  logic                           work_level;
  logic                           work_ignored;
  logic                           work_known;
  logic                           work_fwd;
  bcdc_pkg::entry_t               read_data;
  bcdc_pkg::entry_t               fwd_data;

  // Handshake and write-back
  logic                           accept;
  logic                           advance;
  logic                           mem_write;
  logic [bcdc_pkg::ADDR_W-1:0]    sample_addr;
  logic [bcdc_pkg::ADDR_W-1:0]    work_addr;
  logic                           sample_ignored;

  // Working stage combinational results
  bcdc_pkg::entry_t               entry_cur;
  bcdc_pkg::entry_t               entry_next;
  bcdc_pkg::class_t               event_next;
  logic [bcdc_pkg::CMP_W-1:0]     timer_cmp;

  assign advance      = !result_valid || !result_stall;
  assign sample_stall = work_valid && !advance;
  assign accept       = sample_valid && !sample_stall;
  assign mem_write    = work_valid && advance && !work_ignored;
  assign sample_addr  = bcdc_pkg::ADDR_W'(button_index);
  assign work_addr    = bcdc_pkg::ADDR_W'(work_index);

  // Flag indexes outside the configured or built range
  assign sample_ignored = ({1'b0, button_index} >= buttons_in_use) ||
                          (int'(button_index) >= bcdc_pkg::NUM_BUTTONS);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      buttons_in_use   <= bcdc_pkg::RESET_BUTTONS_IN_USE;
      short_threshold  <= bcdc_pkg::RESET_SHORT_THRESHOLD;
      medium_threshold <= bcdc_pkg::RESET_MEDIUM_THRESHOLD;
      long_threshold   <= bcdc_pkg::RESET_LONG_THRESHOLD;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bcdc_pkg::CFG_BUTTONS_IN_USE:   buttons_in_use   <= cfg_data[bcdc_pkg::COUNT_W-1:0];
        bcdc_pkg::CFG_SHORT_THRESHOLD:  short_threshold  <= cfg_data;
        bcdc_pkg::CFG_MEDIUM_THRESHOLD: medium_threshold <= cfg_data;
        bcdc_pkg::CFG_LONG_THRESHOLD:   long_threshold   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Write back the updated entry
  always_ff @(posedge clk) begin
    if (mem_write) begin
      state_mem[work_addr] <= entry_next;
    end
  end

  // Read the entry of a taken item
  always_ff @(posedge clk) begin
    if (accept) begin
      read_data <= state_mem[sample_addr];
    end
  end

  // Track which entries have been written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (mem_write) begin
      entry_valid[work_addr] <= 1'b1;
    end
  end

  // Advance the working stage; catch a same-entry write for bypass
  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (advance || !work_valid) begin
      work_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      work_index   <= button_index;
      work_level   <= pin_level;
      work_ignored <= sample_ignored;
      work_fwd     <= mem_write && (work_addr == sample_addr);
      work_known   <= entry_valid[sample_addr] || (mem_write && (work_addr == sample_addr));
      fwd_data     <= entry_next;
    end
  end

  // Select the current entry: bypass, memory, or reset value
  always_comb begin
    if (work_fwd) begin
      entry_cur = fwd_data;
    end else if (work_known) begin
      entry_cur = read_data;
    end else begin
      entry_cur = '0;
    end
  end

  // Edge detection, timer update and classification
  always_comb begin
    entry_next = entry_cur;
    event_next = bcdc_pkg::CLASS_NONE;
    if (entry_cur.previous_level && !work_level) begin
      entry_next.timing_active = 1'b1;
      entry_next.released_seen = 1'b0;
    end else if (!entry_cur.previous_level && work_level) begin
      entry_next.timing_active = 1'b0;
      entry_next.released_seen = 1'b1;
    end
    entry_next.previous_level = work_level;

    // Count while timing, hold at full scale
    if (entry_next.timing_active && !(&entry_cur.press_timer)) begin
      entry_next.press_timer = entry_cur.press_timer + 1'b1;
    end
    timer_cmp = bcdc_pkg::CMP_W'(entry_next.press_timer);

    if (entry_next.released_seen) begin
      if (timer_cmp > bcdc_pkg::CMP_W'(long_threshold)) begin
        event_next = bcdc_pkg::CLASS_LONG;
      end else if (timer_cmp > bcdc_pkg::CMP_W'(medium_threshold)) begin
        event_next = bcdc_pkg::CLASS_MEDIUM;
      end else if (timer_cmp > bcdc_pkg::CMP_W'(short_threshold)) begin
        event_next = bcdc_pkg::CLASS_SHORT;
      end
      if (event_next != bcdc_pkg::CLASS_NONE) begin
        entry_next.recorded_class = event_next;
        entry_next.timing_active  = 1'b0;
        entry_next.press_timer    = '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= work_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && work_valid) begin
      result_index <= work_index;
      ignored      <= work_ignored;
      if (work_ignored) begin
        click_event <= bcdc_pkg::CLASS_NONE;
        held_class  <= bcdc_pkg::CLASS_NONE;
      end else begin
        click_event <= event_next;
        held_class  <= entry_next.recorded_class;
      end
    end
  end

  // Checks
  a_ignored_quiet: assert property (@(posedge clk) disable iff (rst)
    (result_valid && ignored) |->
      (click_event == bcdc_pkg::CLASS_NONE && held_class == bcdc_pkg::CLASS_NONE))
    else $error("ignored item carries a click class");

  a_event_recorded: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !ignored && click_event != bcdc_pkg::CLASS_NONE) |->
      (held_class == click_event))
    else $error("decided click not recorded as held class");

  a_no_write_when_held: assert property (@(posedge clk) disable iff (rst)
    (work_valid && !advance) |-> !mem_write)
    else $error("state written while working stage is held");

  a_bypass_marks_known: assert property (@(posedge clk) disable iff (rst)
    (work_valid && work_fwd) |-> work_known)
    else $error("bypassed entry not marked as written");

  a_write_sets_valid: assert property (@(posedge clk) disable iff (rst)
    mem_write |=> entry_valid[$past(work_addr)])
    else $error("written entry not marked valid");

endmodule
